// ----- src/vqp_pkg.sv -----
// Package for the VQP datagram validator: field widths, verdict and phase
// codes, register indexes and the structs passed between modules.
// No dependencies.
`default_nettype none

package vqp_pkg;

    localparam int DATA_W      = 8;
    localparam int OPCODE_W    = 8;
    localparam int TID_W       = 32;
    localparam int ATTR_CNT_W  = 8;
    localparam int LEN_W       = 13;
    localparam int VERDICT_W   = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int VALUE_LEN_W = 16;
    localparam int FPOS_W      = 3;

    typedef enum logic [VERDICT_W-1:0] {
        V_OK        = 3'd0,
        V_SHORT     = 3'd1,
        V_HEADER    = 3'd2,
        V_MALFORMED = 3'd3,
        V_TYPE      = 3'd4,
        V_LENGTH    = 3'd5,
        V_TRUNC     = 3'd6
    } t_verdict;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_ATTR_HDR = 2'd1,
        PH_ATTR_VAL = 2'd2,
        PH_DRAIN    = 2'd3
    } t_phase;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE_LENGTH    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTRIBUTE_COUNT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] RST_MAX_VALUE_LENGTH    = 8'd253;
    localparam logic [CFG_DATA_W-1:0] RST_MAX_ATTRIBUTE_COUNT = 8'd12;

    // Protocol constants
    localparam int                HEADER_BYTES   = 8;
    localparam logic [DATA_W-1:0] PROTO_VERSION  = 8'd1;
    localparam logic [DATA_W-1:0] OPCODE_MIN     = 8'd1;
    localparam logic [DATA_W-1:0] OPCODE_MAX     = 8'd4;
    localparam logic [DATA_W-1:0] ATTR_VENDOR_HI = 8'h00;
    localparam logic [DATA_W-1:0] ATTR_VENDOR_LO = 8'h0c;
    localparam logic [DATA_W-1:0] ATTR_TYPE_MIN  = 8'd1;
    localparam logic [DATA_W-1:0] ATTR_TYPE_MAX  = 8'd8;
    localparam logic [DATA_W-1:0] ATTR_TYPE_ETH  = 8'd5;
    localparam int                ATTR_MIN_BYTES = 7;
    localparam logic [ATTR_CNT_W-1:0] ATTR_CNT_MAX = 8'd255;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } t_byte;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] max_value_length;
        logic [CFG_DATA_W-1:0] max_attribute_count;
    } t_cfg;

    typedef struct packed {
        t_verdict              verdict;
        logic [OPCODE_W-1:0]   packet_opcode;
        logic [TID_W-1:0]      transaction_id;
        logic [ATTR_CNT_W-1:0] attributes_seen;
        logic [LEN_W-1:0]      datagram_length;
    } t_result;

endpackage

`default_nettype wire

// ----- src/vqp_byte_if.sv -----
// Byte stream channel: valid/ready handshake with one datagram byte.
// Depends on vqp_pkg for field widths.
`default_nettype none

interface vqp_byte_if;
    logic                      valid;
    logic                      ready;
    logic [vqp_pkg::DATA_W-1:0] data_byte;
    logic                      last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- src/vqp_result_if.sv -----
// Result channel: valid/ready handshake with one datagram verdict.
// Depends on vqp_pkg for field widths.
`default_nettype none

interface vqp_result_if;
    logic                          valid;
    logic                          ready;
    logic [vqp_pkg::VERDICT_W-1:0]  verdict;
    logic [vqp_pkg::OPCODE_W-1:0]   packet_opcode;
    logic [vqp_pkg::TID_W-1:0]      transaction_id;
    logic [vqp_pkg::ATTR_CNT_W-1:0] attributes_seen;
    logic [vqp_pkg::LEN_W-1:0]      datagram_length;

    modport source (output valid, output verdict, output packet_opcode,
                    output transaction_id, output attributes_seen,
                    output datagram_length, input ready);
    modport sink   (input valid, input verdict, input packet_opcode,
                    input transaction_id, input attributes_seen,
                    input datagram_length, output ready);
endinterface

`default_nettype wire

// ----- src/vqp_packet_validator.sv -----
// Top level of the VQP datagram validator: configuration registers, input
// stage, parser and result register. Depends on vqp_pkg, vqp_byte_if,
// vqp_result_if, vqp_in_reg and vqp_parser.
//
// Usage:
//   i_in carries one datagram byte per transaction, with last_byte set on
//   the closing byte. o_out carries one verdict transaction per datagram,
//   issued for the closing byte; no other byte produces a result.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) land at the
//   next clock edge; write them only while no datagram is in flight.
// Throughput: one byte per cycle while no closing byte stalls (see Stall),
//   set by the parser step between input register and result register.
// Path: the closing byte is registered in the input stage, and its verdict
//   in the result register driving o_out (two register stages end to end).
// Reset: synchronous active-low i_rst_n empties both stages, returns the
//   parser to the header phase and loads the register defaults (253, 12).
//   No clearing pass is needed.
// Stall: a held verdict does not block bytes of the next datagram; only
//   when a second closing byte meets a full result register do the input
//   stage and i_in.ready hold until o_out drains.
`default_nettype none

module vqp_packet_validator #(
    parameter int MAX_DATAGRAM_BYTES = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    vqp_byte_if.sink                              i_in,
    vqp_result_if.source                          o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [vqp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [vqp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    vqp_pkg::t_cfg    r_cfg;
    logic             w_stage_valid;
    vqp_pkg::t_byte   w_stage_byte;
    logic             w_advance;
    logic             w_done;
    vqp_pkg::t_result w_result;
    logic             r_out_valid;
    vqp_pkg::t_result r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_value_length    <= vqp_pkg::RST_MAX_VALUE_LENGTH;
            r_cfg.max_attribute_count <= vqp_pkg::RST_MAX_ATTRIBUTE_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vqp_pkg::CFG_MAX_VALUE_LENGTH:    r_cfg.max_value_length    <= i_cfg_data;
                vqp_pkg::CFG_MAX_ATTRIBUTE_COUNT: r_cfg.max_attribute_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the held byte unless it closes a datagram and the result
    // register is still occupied
    assign w_advance = w_stage_valid &&
                       (!w_stage_byte.last_byte || !r_out_valid || o_out.ready);

    vqp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_stage_valid),
        .o_byte    (w_stage_byte)
    );

    vqp_parser #(
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (w_stage_byte),
        .i_cfg    (r_cfg),
        .o_done   (w_done),
        .o_result (w_result)
    );

    // Result register: load on a closing byte, drop on an output transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.verdict         = r_out.verdict;
    assign o_out.packet_opcode   = r_out.packet_opcode;
    assign o_out.transaction_id  = r_out.transaction_id;
    assign o_out.attributes_seen = r_out.attributes_seen;
    assign o_out.datagram_length = r_out.datagram_length;

    // Never overwrite a verdict that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_out_valid || o_out.ready)
        else $error("result register overwritten");

    // A closing byte always produces a verdict in the next cycle
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> r_out_valid)
        else $error("closing byte gave no verdict");

    // Only a closing byte blocked by a full output may hold the input stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage_valid && !w_advance |-> w_stage_byte.last_byte && r_out_valid)
        else $error("input stage stalled without cause");

endmodule

`default_nettype wire

// ----- src/vqp_in_reg.sv -----
// Input register stage: captures one byte transaction and holds it until
// the parser consumes it. Depends on vqp_pkg and vqp_byte_if.
`default_nettype none

module vqp_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    vqp_byte_if.sink           i_in,
    input  wire logic          i_advance,
    output      logic          o_valid,
    output      vqp_pkg::t_byte o_byte
);

    logic           r_valid;
    vqp_pkg::t_byte r_byte;
    logic           w_take;

    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte.data_byte <= i_in.data_byte;
            r_byte.last_byte <= i_in.last_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // A full stage that does not drain must refuse new bytes
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_advance |-> !i_in.ready)
        else $error("input stage accepted a byte while full");

    // Consume only what is held
    a_adv_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |-> r_valid)
        else $error("advance with empty input stage");

endmodule

`default_nettype wire

// ----- src/vqp_parser.sv -----
// Datagram parser: per-byte header and attribute state machine with the
// final verdict for the closing byte. Depends on vqp_pkg.
`default_nettype none

module vqp_parser #(
    parameter int MAX_DATAGRAM_BYTES = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire vqp_pkg::t_byte  i_byte,
    input  wire vqp_pkg::t_cfg   i_cfg,
    output      logic            o_done,
    output      vqp_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATAGRAM_BYTES);

    vqp_pkg::t_phase   r_phase,   n_phase;
    logic [CNT_W-1:0]  r_cnt,     n_cnt;
    logic [vqp_pkg::FPOS_W-1:0]      r_fpos,   n_fpos;
    logic [vqp_pkg::OPCODE_W-1:0]    r_opcode, n_opcode;
    logic [vqp_pkg::TID_W-1:0]       r_seq,    n_seq;
    logic [vqp_pkg::DATA_W-1:0]      r_atype,  n_atype;
    logic [vqp_pkg::VALUE_LEN_W-1:0] r_alen,   n_alen;
    logic [vqp_pkg::VALUE_LEN_W-1:0] r_vleft,  n_vleft;
    logic [CNT_W-1:0]  r_start,   n_start;
    vqp_pkg::t_verdict r_pending, n_pending;
    vqp_pkg::t_verdict r_comm,    n_comm;
    logic [vqp_pkg::ATTR_CNT_W-1:0]  r_acnt,   n_acnt;

    logic [vqp_pkg::DATA_W-1:0]      w_b;
    logic [vqp_pkg::VALUE_LEN_W-1:0] w_len;
    logic [CNT_W:0]                  w_commit_at;
    logic [CNT_W-1:0]                w_span;
    logic [CNT_W+vqp_pkg::LEN_W-1:0] w_len_ext;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_fpos    = r_fpos;
        n_opcode  = r_opcode;
        n_seq     = r_seq;
        n_atype   = r_atype;
        n_alen    = r_alen;
        n_vleft   = r_vleft;
        n_start   = r_start;
        n_pending = r_pending;
        n_comm    = r_comm;
        n_acnt    = r_acnt;
        w_b         = i_byte.data_byte;
        w_len       = {r_alen[vqp_pkg::VALUE_LEN_W-1:vqp_pkg::DATA_W], w_b};
        w_commit_at = {1'b0, r_start} + (CNT_W+1)'(6);

        if (i_step && (r_cnt < MAX_CNT)) begin
            n_cnt = r_cnt + CNT_W'(1);

            // Commit the attribute's error once its seventh byte arrives
            if ((r_phase == vqp_pkg::PH_ATTR_HDR || r_phase == vqp_pkg::PH_ATTR_VAL) &&
                r_start != '0 && {1'b0, r_cnt} == w_commit_at &&
                r_pending != vqp_pkg::V_OK) begin
                if (n_comm == vqp_pkg::V_OK) n_comm = r_pending;
                n_phase = vqp_pkg::PH_DRAIN;
            end

            case (n_phase)
                vqp_pkg::PH_HEADER: begin
                    case (r_cnt[2:0])
                        3'd0: begin
                            if (w_b != vqp_pkg::PROTO_VERSION && n_comm == vqp_pkg::V_OK)
                                n_comm = vqp_pkg::V_HEADER;
                        end
                        3'd1: begin
                            n_opcode = w_b;
                            if ((w_b < vqp_pkg::OPCODE_MIN || w_b > vqp_pkg::OPCODE_MAX) &&
                                n_comm == vqp_pkg::V_OK)
                                n_comm = vqp_pkg::V_HEADER;
                        end
                        3'd3: begin
                            if (w_b > i_cfg.max_attribute_count && n_comm == vqp_pkg::V_OK)
                                n_comm = vqp_pkg::V_HEADER;
                        end
                        3'd4: n_seq[31:24] = w_b;
                        3'd5: n_seq[23:16] = w_b;
                        3'd6: n_seq[15:8]  = w_b;
                        3'd7: begin
                            n_seq[7:0] = w_b;
                            n_phase = (n_comm != vqp_pkg::V_OK) ? vqp_pkg::PH_DRAIN
                                                                : vqp_pkg::PH_ATTR_HDR;
                            n_fpos  = '0;
                        end
                        default: ;
                    endcase
                end
                vqp_pkg::PH_ATTR_HDR: begin
                    n_fpos = r_fpos + vqp_pkg::FPOS_W'(1);
                    case (r_fpos)
                        3'd0: begin
                            n_start   = r_cnt;
                            n_pending = (w_b != vqp_pkg::ATTR_VENDOR_HI) ? vqp_pkg::V_TYPE
                                                                         : vqp_pkg::V_OK;
                        end
                        3'd1: begin
                            if (w_b != vqp_pkg::ATTR_VENDOR_HI && r_pending == vqp_pkg::V_OK)
                                n_pending = vqp_pkg::V_TYPE;
                        end
                        3'd2: begin
                            if (w_b != vqp_pkg::ATTR_VENDOR_LO && r_pending == vqp_pkg::V_OK)
                                n_pending = vqp_pkg::V_TYPE;
                        end
                        3'd3: begin
                            n_atype = w_b;
                            if ((w_b < vqp_pkg::ATTR_TYPE_MIN || w_b > vqp_pkg::ATTR_TYPE_MAX) &&
                                r_pending == vqp_pkg::V_OK)
                                n_pending = vqp_pkg::V_TYPE;
                        end
                        3'd4: begin
                            n_alen = {w_b, vqp_pkg::DATA_W'(0)};
                        end
                        default: begin
                            // Length low byte closes the attribute header
                            n_alen = w_len;
                            if (r_pending == vqp_pkg::V_OK && r_atype != vqp_pkg::ATTR_TYPE_ETH &&
                                (r_alen[vqp_pkg::VALUE_LEN_W-1:vqp_pkg::DATA_W] != '0 ||
                                 w_b > i_cfg.max_value_length))
                                n_pending = vqp_pkg::V_LENGTH;
                            if (r_acnt < vqp_pkg::ATTR_CNT_MAX)
                                n_acnt = r_acnt + vqp_pkg::ATTR_CNT_W'(1);
                            n_vleft = w_len;
                            n_phase = (w_len != '0) ? vqp_pkg::PH_ATTR_VAL
                                                    : vqp_pkg::PH_ATTR_HDR;
                            n_fpos  = '0;
                        end
                    endcase
                end
                vqp_pkg::PH_ATTR_VAL: begin
                    n_vleft = r_vleft - vqp_pkg::VALUE_LEN_W'(1);
                    if (n_vleft == '0) begin
                        n_phase = vqp_pkg::PH_ATTR_HDR;
                        n_fpos  = '0;
                    end
                end
                default: ;
            endcase
        end

        // Verdict from the state after this byte
        w_span    = n_cnt - n_start;
        w_len_ext = (CNT_W+vqp_pkg::LEN_W)'(n_cnt);
        if (n_cnt < CNT_W'(vqp_pkg::HEADER_BYTES))
            o_result.verdict = vqp_pkg::V_SHORT;
        else if (n_comm != vqp_pkg::V_OK)
            o_result.verdict = n_comm;
        else if (n_start != '0 && w_span < CNT_W'(vqp_pkg::ATTR_MIN_BYTES))
            o_result.verdict = vqp_pkg::V_MALFORMED;
        else if (n_pending != vqp_pkg::V_OK)
            o_result.verdict = n_pending;
        else if (n_phase == vqp_pkg::PH_ATTR_VAL && n_vleft != '0)
            o_result.verdict = vqp_pkg::V_TRUNC;
        else
            o_result.verdict = vqp_pkg::V_OK;
        o_result.packet_opcode   = n_opcode;
        o_result.transaction_id  = n_seq;
        o_result.attributes_seen = n_acnt;
        o_result.datagram_length = w_len_ext[vqp_pkg::LEN_W-1:0];

        o_done = i_step && i_byte.last_byte;

        // Return to the idle datagram state after the closing byte
        if (o_done) begin
            n_phase   = vqp_pkg::PH_HEADER;
            n_cnt     = '0;
            n_fpos    = '0;
            n_opcode  = '0;
            n_seq     = '0;
            n_atype   = '0;
            n_alen    = '0;
            n_vleft   = '0;
            n_start   = '0;
            n_pending = vqp_pkg::V_OK;
            n_comm    = vqp_pkg::V_OK;
            n_acnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= vqp_pkg::PH_HEADER;
            r_cnt     <= '0;
            r_fpos    <= '0;
            r_opcode  <= '0;
            r_seq     <= '0;
            r_atype   <= '0;
            r_alen    <= '0;
            r_vleft   <= '0;
            r_start   <= '0;
            r_pending <= vqp_pkg::V_OK;
            r_comm    <= vqp_pkg::V_OK;
            r_acnt    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_fpos    <= n_fpos;
            r_opcode  <= n_opcode;
            r_seq     <= n_seq;
            r_atype   <= n_atype;
            r_alen    <= n_alen;
            r_vleft   <= n_vleft;
            r_start   <= n_start;
            r_pending <= n_pending;
            r_comm    <= n_comm;
            r_acnt    <= n_acnt;
        end
    end

    a_val_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == vqp_pkg::PH_ATTR_VAL |-> r_vleft != '0)
        else $error("value phase with no bytes left");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("byte counter past datagram limit");

    a_comm_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comm != vqp_pkg::V_OK && r_cnt >= CNT_W'(vqp_pkg::HEADER_BYTES)
        |-> r_phase == vqp_pkg::PH_DRAIN)
        else $error("committed error without drain");

    a_fpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fpos <= vqp_pkg::FPOS_W'(5))
        else $error("attribute field position out of range");

endmodule

`default_nettype wire
